// ===== rtl/cbch_pkg.sv =====
// ----------------------------------------------------------------------------
// cbch_pkg
// Shared types, constants and functions of the CLTU BCH(63,56) decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbch_pkg;

  localparam int unsigned MAX_BLOCKS = 32;
  localparam int unsigned MaxCount   = MAX_BLOCKS * 7;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [63:0] TailReset   = 64'hC5C5_C5C5_C5C5_C579;
  localparam logic [5:0]  SkipReset   = 6'd4;
  localparam logic [7:0]  ScramblerSeed = 8'hFF;
  localparam logic [6:0]  BchPoly     = 7'h45;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TAIL_PATTERN = 2'd0,
    REG_SKIP_LIMIT   = 2'd1,
    REG_DERAND_EN    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_INPUT_END = 2'd0,
    CAUSE_TAIL      = 2'd1,
    CAUSE_PARITY    = 2'd2,
    CAUSE_CAPACITY  = 2'd3
  } cause_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_summary;
    logic [7:0] byte_count;
    logic [1:0] stop_cause;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [63:0] tail_pattern;
    logic [5:0]  lead_skip_limit;
    logic        derandomize_enable;
  } cfg_t;

  // work handed from the front end to the output sequencer
  typedef struct packed {
    logic            has_block;
    logic            has_summary;
    logic [6:0][7:0] data;       // [6] is the first data byte
    logic [7:0]      count;
    cause_e          cause;
  } job_t;

  // bit-serial BCH remainder; only used at elaboration to build the masks
  function automatic logic [6:0] bch_serial(logic [55:0] d);
    logic [6:0] sr;
    logic       fb;
    sr = '0;
    for (int i = 55; i >= 0; i--) begin
      fb = sr[6] ^ d[i];
      sr = {sr[5:0], 1'b0};
      if (fb) sr = sr ^ BchPoly;
    end
    return sr;
  endfunction

  function automatic logic [6:0][55:0] bch_masks();
    logic [6:0][55:0] m;
    logic [6:0]       r;
    m = '0;
    for (int i = 0; i < 56; i++) begin
      r = bch_serial(56'(1) << i);
      for (int j = 0; j < 7; j++) m[j][i] = r[j];
    end
    return m;
  endfunction

  localparam logic [6:0][55:0] BchMask = bch_masks();

  // parity octet: complemented remainder, filler bit zero
  function automatic logic [7:0] bch_parity(logic [55:0] d);
    logic [6:0] r;
    for (int j = 0; j < 7; j++) r[j] = ^(d & BchMask[j]);
    return {~r, 1'b0};
  endfunction

  // CCSDS pseudo-random byte (x^8+x^7+x^5+x^3+1), first bit in the MSB
  function automatic logic [7:0] rand_byte(logic [7:0] s_in);
    logic [7:0] s;
    logic [7:0] rnd;
    logic       fb;
    s   = s_in;
    rnd = '0;
    for (int b = 0; b < 8; b++) begin
      rnd = {rnd[6:0], s[0]};
      fb  = s[0] ^ s[3] ^ s[5] ^ s[7];
      s   = {fb, s[7:1]};
    end
    return rnd;
  endfunction

  function automatic logic [7:0] rand_next(logic [7:0] s_in);
    logic [7:0] s;
    logic       fb;
    s = s_in;
    for (int b = 0; b < 8; b++) begin
      fb = s[0] ^ s[3] ^ s[5] ^ s[7];
      s  = {fb, s[7:1]};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cltu_bch_decoder.sv =====
// ----------------------------------------------------------------------------
// cltu_bch_decoder
// CLTU codeblock decoder with BCH(63,56) check and CCSDS derandomizer.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the job queue has room. The front
// end hunts for the first codeblock, then checks each aligned 8-byte block
// combinationally through a fixed XOR tree. Results leave through a
// registered output one per cycle while out_ready_i is high: an accepted
// block gives 7 data bytes, the end of a packet one summary item. Since a
// block takes 8 input bytes, the output keeps pace with one input byte per
// cycle; a 4-entry job queue between the front end and the output sequencer
// absorbs output stalls and summary bursts. The first data byte of a block
// passes through the job queue and then the output register.
`default_nettype none

module cltu_bch_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_idx_i,
  input  wire logic [63:0]    cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire cbch_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output cbch_pkg::out_t      out_data_o
);

  cbch_pkg::cfg_t cfg_q;
  cbch_pkg::job_t push_job, head_job;
  logic           push, pop, q_empty, q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tail_pattern       <= cbch_pkg::TailReset;
      cfg_q.lead_skip_limit    <= cbch_pkg::SkipReset;
      cfg_q.derandomize_enable <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbch_pkg::REG_TAIL_PATTERN: cfg_q.tail_pattern       <= cfg_data_i;
        cbch_pkg::REG_SKIP_LIMIT:   cfg_q.lead_skip_limit    <= cfg_data_i[5:0];
        cbch_pkg::REG_DERAND_EN:    cfg_q.derandomize_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cbch_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  cbch_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  cbch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .derand_en_i (cfg_q.derandomize_enable),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/cbch_front.sv =====
// ----------------------------------------------------------------------------
// cbch_front
// Byte window, codeblock hunt and block check; emits one job per input byte
// that causes results.
// ----------------------------------------------------------------------------
`default_nettype none

module cbch_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cbch_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cbch_pkg::in_t in_data_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output cbch_pkg::job_t     job_o
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_ALIGNED = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  logic [63:0]       win_q, win_d, win_sh;
  logic [6:0]        seen_q, seen_d, seen_inc, offset;
  phase_e            phase_q, phase_d;
  logic [2:0]        pos_q, pos_d;
  logic [7:0]        rec_q, rec_d;
  cbch_pkg::cause_e  reason_q, reason_d;
  logic              accept, check, tail_hit, par_ok;
  cbch_pkg::job_t    job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign win_sh   = {win_q[55:0], in_data_i.rx_byte};
  assign tail_hit = (win_sh == cfg_i.tail_pattern);
  assign par_ok   = (cbch_pkg::bch_parity(win_sh[63:8]) == win_sh[7:0]);
  assign seen_inc = (seen_q == 7'd127) ? seen_q : seen_q + 7'd1;
  assign offset   = seen_inc - 7'd8;

  always_comb begin
    win_d    = win_q;
    seen_d   = seen_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    rec_d    = rec_q;
    reason_d = reason_q;
    check    = 1'b0;
    job      = '0;

    case (phase_q)
      PH_HUNT: begin
        win_d  = win_sh;
        seen_d = seen_inc;
        if (seen_inc >= 7'd8) begin
          if (offset >= {1'b0, cfg_i.lead_skip_limit} || tail_hit || par_ok) check = 1'b1;
        end
      end
      PH_ALIGNED: begin
        win_d = win_sh;
        if (pos_q == 3'd7) check = 1'b1;
        else pos_d = pos_q + 3'd1;
      end
      default: ;
    endcase

    if (check) begin
      if (tail_hit) begin
        phase_d  = PH_STOPPED;
        reason_d = cbch_pkg::CAUSE_TAIL;
      end else if (!par_ok) begin
        phase_d  = PH_STOPPED;
        reason_d = cbch_pkg::CAUSE_PARITY;
      end else if ({1'b0, rec_q} + 9'd7 > 9'(cbch_pkg::MaxCount)) begin
        phase_d  = PH_STOPPED;
        reason_d = cbch_pkg::CAUSE_CAPACITY;
      end else begin
        job.has_block = 1'b1;
        job.data      = win_sh[63:8];
        rec_d         = rec_q + 8'd7;
        phase_d       = PH_ALIGNED;
        pos_d         = '0;
      end
    end

    job.count = rec_d;
    job.cause = (phase_d == PH_STOPPED) ? reason_d : cbch_pkg::CAUSE_INPUT_END;

    // end of packet: summary, then back to the per-packet reset state
    if (in_data_i.last_byte) begin
      job.has_summary = 1'b1;
      win_d    = '0;
      seen_d   = '0;
      phase_d  = PH_HUNT;
      pos_d    = '0;
      rec_d    = '0;
      reason_d = cbch_pkg::CAUSE_INPUT_END;
    end
  end

  assign push_o = accept && (job.has_block || job.has_summary);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      seen_q   <= '0;
      phase_q  <= PH_HUNT;
      pos_q    <= '0;
      rec_q    <= '0;
      reason_q <= cbch_pkg::CAUSE_INPUT_END;
    end else if (accept) begin
      win_q    <= win_d;
      seen_q   <= seen_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      rec_q    <= rec_d;
      reason_q <= reason_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cbch_queue.sv =====
// ----------------------------------------------------------------------------
// cbch_queue
// Short job FIFO between the front end and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cbch_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cbch_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output cbch_pkg::job_t      head_o,
  output logic                empty_o,
  output logic                full_o
);

  cbch_pkg::job_t                 mem_q [cbch_pkg::QDepth];
  logic [cbch_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [cbch_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == cbch_pkg::QCntW'(cbch_pkg::QDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cbch_back.sv =====
// ----------------------------------------------------------------------------
// cbch_back
// Output sequencer: expands each job into data bytes and the summary,
// derandomizes, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbch_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           derand_en_i,
  input  wire cbch_pkg::job_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output cbch_pkg::out_t      out_data_o
);

  logic [2:0]      idx_q, idx_d;
  logic [7:0]      scr_q, scr_d;
  logic            valid_q, valid_d;
  cbch_pkg::out_t  out_q, out_d;
  logic            load, emit_data;
  logic [7:0]      data_byte;

  assign load      = !valid_q || out_ready_i;
  assign emit_data = head_i.has_block && (idx_q != 3'd7);
  assign data_byte = head_i.data[3'd6 - idx_q];

  always_comb begin
    idx_d   = idx_q;
    scr_d   = scr_q;
    valid_d = valid_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        out_d = '0;
        if (emit_data) begin
          out_d.out_byte = derand_en_i ? (data_byte ^ cbch_pkg::rand_byte(scr_q)) : data_byte;
          scr_d = cbch_pkg::rand_next(scr_q);
          if (idx_q == 3'd6) begin
            out_d.last_of_run = !head_i.has_summary;
            if (head_i.has_summary) begin
              idx_d = 3'd7;
            end else begin
              idx_d = '0;
              pop_o = 1'b1;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end else begin
          out_d.is_summary  = 1'b1;
          out_d.byte_count  = head_i.count;
          out_d.stop_cause  = head_i.cause;
          out_d.last_of_run = 1'b1;
          scr_d = cbch_pkg::ScramblerSeed;   // new packet restarts the sequence
          idx_d = '0;
          pop_o = 1'b1;
        end
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      scr_q   <= cbch_pkg::ScramblerSeed;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      scr_q   <= scr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire
